>>> sv/dependency_topological_sorter_top_defines.svh
// ----------------------------------------------------------------------------
// Dependency topological sorter: assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef DEPENDENCY_TOPOLOGICAL_SORTER_TOP_DEFINES_SVH
`define DEPENDENCY_TOPOLOGICAL_SORTER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define DTS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("dts assertion failed");
`define DTS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("dts forbidden condition seen");
`else
`define DTS_ASSERT(lbl, clk, rst_n, prop)
`define DTS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> sv/dts_pkg.sv
// ----------------------------------------------------------------------------
// Dependency topological sorter package
// Widths, action and result codes, controller/datapath interface structs.
// ----------------------------------------------------------------------------
package dts_pkg;

	localparam int MAX_NODES_DEF = 32;
	localparam int MAX_EDGES_DEF = 256;

	localparam int ACT_W   = 2;
	localparam int NODE_W  = 5;
	localparam int COUNT_W = 6;
	localparam int MASK_W  = 32;
	localparam int KIND_W  = 3;

	localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RUN   = 2'd2;

	localparam logic [KIND_W-1:0] KIND_STORED   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_BAD_NODE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FULL     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_NODE     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SUMMARY  = 3'd4;

	typedef struct packed {
		logic edge_add;
		logic edge_clear;
		logic run_start;
		logic scan_issue;
		logic count_en;
		logic dec_en;
		logic seed_step;
		logic pop;
		logic emit_summary;
	} dts_cmd_t;

	typedef struct packed {
		logic scan_more;
		logic scan_busy;
		logic seed_more;
		logic fifo_avail;
		logic out_free;
	} dts_sts_t;

endpackage

>>> sv/dependency_topological_sorter_top.sv
// ----------------------------------------------------------------------------
// Dependency topological sorter
// Kahn topological sort over a stored edge list, controller plus datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall) carries action, edge_from, edge_to.
//   Response channel (rsp_valid/rsp_stall) carries kind, node_index,
//   sorted_count, cyclic_mask and last; last marks an item's final result.
//   cfg_we/cfg_wdata write node_count (saturated to MAX_NODES) while idle.
//   Add edge: one result, valid in the cycle after accept; one item per cycle while the result is not stalled.
//   Clear and the unused action give no result.
//   Run: each sorted node and the summary go out through a single result
//   register. The rate is set by the edge memory, read one entry per cycle
//   for the in-degree count and again for every popped node.
//   A stalled result holds the controller in idle and at each pop; no new item is taken meanwhile.
//   Reset clears node_count, the edge count and all control state; the
//   edge memory needs no clearing pass.
// ----------------------------------------------------------------------------
module dependency_topological_sorter_top #(
	parameter int MAX_NODES = dts_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = dts_pkg::MAX_EDGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dts_pkg::COUNT_W-1:0] cfg_wdata,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [dts_pkg::ACT_W-1:0]   action,
	input  logic [dts_pkg::NODE_W-1:0]  edge_from,
	input  logic [dts_pkg::NODE_W-1:0]  edge_to,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [dts_pkg::KIND_W-1:0]  kind,
	output logic [dts_pkg::NODE_W-1:0]  node_index,
	output logic [dts_pkg::COUNT_W-1:0] sorted_count,
	output logic [dts_pkg::MASK_W-1:0]  cyclic_mask,
	output logic                        last
);
	import dts_pkg::*;

	dts_cmd_t cmd;
	dts_sts_t sts;

	dts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.action    (action),
		.sts       (sts),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	dts_datapath #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.edge_from    (edge_from),
		.edge_to      (edge_to),
		.cmd          (cmd),
		.sts          (sts),
		.rsp_stall    (rsp_stall),
		.rsp_valid    (rsp_valid),
		.kind         (kind),
		.node_index   (node_index),
		.sorted_count (sorted_count),
		.cyclic_mask  (cyclic_mask),
		.last         (last)
	);

endmodule

>>> sv/dts_ctrl.sv
// ----------------------------------------------------------------------------
// Dependency topological sorter controller
// Sequences edge loading, in-degree count, seeding, pops and edge scans.
// ----------------------------------------------------------------------------
module dts_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	input  logic [dts_pkg::ACT_W-1:0] action,
	input  dts_pkg::dts_sts_t        sts,
	output logic                     req_stall,
	output dts_pkg::dts_cmd_t        cmd
);
	import dts_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_COUNT = 3'd1;
	localparam logic [2:0] ST_SEED  = 3'd2;
	localparam logic [2:0] ST_POP   = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = !sts.out_free;
				if (req_valid && sts.out_free) begin
					unique case (action)
						ACT_ADD:   cmd.edge_add = 1'b1;
						ACT_CLEAR: cmd.edge_clear = 1'b1;
						ACT_RUN: begin
							cmd.run_start = 1'b1;
							state_d       = ST_COUNT;
						end
						default: ;
					endcase
				end
			end
			ST_COUNT: begin
				cmd.count_en   = 1'b1;
				cmd.scan_issue = sts.scan_more;
				if (!sts.scan_more && !sts.scan_busy) state_d = ST_SEED;
			end
			ST_SEED: begin
				cmd.seed_step = sts.seed_more;
				if (!sts.seed_more) state_d = ST_POP;
			end
			ST_POP: begin
				if (sts.out_free) begin
					if (sts.fifo_avail) begin
						cmd.pop = 1'b1;
						state_d = ST_SCAN;
					end else begin
						cmd.emit_summary = 1'b1;
						state_d          = ST_IDLE;
					end
				end
			end
			ST_SCAN: begin
				cmd.dec_en     = 1'b1;
				cmd.scan_issue = sts.scan_more;
				if (!sts.scan_more && !sts.scan_busy) state_d = ST_POP;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

>>> sv/dts_datapath.sv
// ----------------------------------------------------------------------------
// Dependency topological sorter datapath
// Edge memory, in-degree registers, ready FIFO and result register.
// ----------------------------------------------------------------------------
`include "dependency_topological_sorter_top_defines.svh"

module dts_datapath #(
	parameter int MAX_NODES = dts_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = dts_pkg::MAX_EDGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dts_pkg::COUNT_W-1:0] cfg_wdata,
	input  logic [dts_pkg::NODE_W-1:0]  edge_from,
	input  logic [dts_pkg::NODE_W-1:0]  edge_to,
	input  dts_pkg::dts_cmd_t           cmd,
	output dts_pkg::dts_sts_t           sts,
	input  logic                        rsp_stall,
	output logic                        rsp_valid,
	output logic [dts_pkg::KIND_W-1:0]  kind,
	output logic [dts_pkg::NODE_W-1:0]  node_index,
	output logic [dts_pkg::COUNT_W-1:0] sorted_count,
	output logic [dts_pkg::MASK_W-1:0]  cyclic_mask,
	output logic                        last
);
	import dts_pkg::*;

	localparam int AW = $clog2(MAX_EDGES);
	localparam int EW = $clog2(MAX_EDGES + 1);
	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int DW = EW;

	logic [COUNT_W-1:0]    node_cnt_q;
	logic [EW-1:0]         edge_total_q;
	logic [2*NODE_W-1:0]   edge_mem_q [MAX_EDGES];
	logic [EW-1:0]         scan_idx_q;
	logic [2*NODE_W-1:0]   rd_data_s1;
	logic                  rd_vld_s1;
	logic [DW-1:0]         deg_q [MAX_NODES];
	logic [NODE_W-1:0]     fifo_q [MAX_NODES];
	logic [CW-1:0]         head_q;
	logic [CW-1:0]         tail_q;
	logic [CW-1:0]         seed_idx_q;
	logic [NODE_W-1:0]     cur_q;
	logic                  out_valid_q;
	logic [KIND_W-1:0]     kind_q;
	logic [NODE_W-1:0]     node_q;
	logic [COUNT_W-1:0]    count_q;
	logic [MASK_W-1:0]     mask_q;
	logic                  last_q;

	logic                  edge_bad;
	logic                  edge_full;
	logic                  edge_store;
	logic [NODE_W-1:0]     rd_from;
	logic [NODE_W-1:0]     rd_to;
	logic                  rd_in_range;
	logic                  rd_hit;
	logic [NW-1:0]         deg_addr;
	logic [DW-1:0]         deg_rd;
	logic                  deg_zero;
	logic                  seed_push;
	logic                  dec_push;
	logic                  push;
	logic [NODE_W-1:0]     push_val;
	logic [MASK_W-1:0]     mask;
	logic                  out_free;
	logic                  emit;

	assign edge_bad   = ({1'b0, edge_from} >= node_cnt_q) || ({1'b0, edge_to} >= node_cnt_q);
	assign edge_full  = edge_total_q >= EW'(MAX_EDGES);
	assign edge_store = cmd.edge_add && !edge_bad && !edge_full;

	assign rd_from     = rd_data_s1[NODE_W-1:0];
	assign rd_to       = rd_data_s1[2*NODE_W-1:NODE_W];
	assign rd_in_range = ({1'b0, rd_from} < node_cnt_q) && ({1'b0, rd_to} < node_cnt_q);
	assign rd_hit      = rd_vld_s1 && rd_in_range;

	assign deg_addr = cmd.seed_step ? seed_idx_q[NW-1:0] : rd_to[NW-1:0];
	assign deg_rd   = deg_q[deg_addr];
	assign deg_zero = (deg_rd == '0);

	assign seed_push = cmd.seed_step && deg_zero;
	assign dec_push  = cmd.dec_en && rd_hit && (rd_from == cur_q) && (deg_rd == DW'(1));
	assign push      = seed_push || dec_push;
	assign push_val  = seed_push ? NODE_W'(seed_idx_q) : rd_to;

	always_comb begin
		mask = '0;
		for (int i = 0; i < MAX_NODES; i++) mask[i] = |deg_q[i];
	end

	assign out_free = !out_valid_q || !rsp_stall;
	assign emit     = cmd.edge_add || cmd.pop || cmd.emit_summary;

	assign sts.scan_more  = scan_idx_q < edge_total_q;
	assign sts.scan_busy  = rd_vld_s1;
	assign sts.seed_more  = COUNT_W'(seed_idx_q) < node_cnt_q;
	assign sts.fifo_avail = head_q < tail_q;
	assign sts.out_free   = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_cnt_q   <= '0;
			edge_total_q <= '0;
			scan_idx_q   <= '0;
			rd_vld_s1    <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
			seed_idx_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we)
				node_cnt_q <= (cfg_wdata > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : cfg_wdata;
			if (cmd.edge_clear) edge_total_q <= '0;
			else if (edge_store) edge_total_q <= edge_total_q + EW'(1);
			if (cmd.run_start || cmd.pop) scan_idx_q <= '0;
			else if (cmd.scan_issue) scan_idx_q <= scan_idx_q + EW'(1);
			rd_vld_s1 <= cmd.scan_issue;
			if (cmd.run_start) begin
				head_q     <= '0;
				tail_q     <= '0;
				seed_idx_q <= '0;
			end else begin
				if (cmd.pop) head_q <= head_q + CW'(1);
				if (push) tail_q <= tail_q + CW'(1);
				if (cmd.seed_step) seed_idx_q <= seed_idx_q + CW'(1);
			end
			if (emit) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (edge_store) edge_mem_q[edge_total_q[AW-1:0]] <= {edge_to, edge_from};
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_issue) rd_data_s1 <= edge_mem_q[scan_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.run_start) begin
			for (int i = 0; i < MAX_NODES; i++) deg_q[i] <= '0;
		end else if (rd_hit) begin
			if (cmd.count_en) deg_q[deg_addr] <= deg_rd + DW'(1);
			else if (cmd.dec_en && (rd_from == cur_q) && !deg_zero)
				deg_q[deg_addr] <= deg_rd - DW'(1);
		end
		if (push) fifo_q[tail_q[NW-1:0]] <= push_val;
		if (cmd.pop) cur_q <= fifo_q[head_q[NW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= KIND_STORED;
			node_q  <= '0;
			count_q <= '0;
			mask_q  <= '0;
			last_q  <= 1'b1;
			if (cmd.edge_add) begin
				if (edge_bad) kind_q <= KIND_BAD_NODE;
				else if (edge_full) kind_q <= KIND_FULL;
			end else if (cmd.pop) begin
				kind_q <= KIND_NODE;
				node_q <= fifo_q[head_q[NW-1:0]];
				last_q <= 1'b0;
			end else begin
				kind_q  <= KIND_SUMMARY;
				count_q <= COUNT_W'(head_q);
				mask_q  <= mask;
			end
		end
	end

	assign rsp_valid    = out_valid_q;
	assign kind         = kind_q;
	assign node_index   = node_q;
	assign sorted_count = count_q;
	assign cyclic_mask  = mask_q;
	assign last         = last_q;

	`DTS_ASSERT(a_head_le_tail, clk, arst_n, head_q <= tail_q)
	`DTS_ASSERT(a_tail_le_max, clk, arst_n, tail_q <= CW'(MAX_NODES))
	`DTS_ASSERT(a_edge_total_le_max, clk, arst_n, edge_total_q <= EW'(MAX_EDGES))
	`DTS_ASSERT_NEVER(a_emit_over_held, clk, arst_n, emit && !out_free)

endmodule

>>> dv/tb_dependency_topological_sorter_top.sv
// ----------------------------------------------------------------------------
// Dependency topological sorter testbench
// Sends add-edge, clear, run and unused items and predicts the Kahn order and the
// cyclic summary that each one gives. Every result field is compared, under
// random gaps on the request side, random stalls on the response side and
// one long hold-off on the responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dependency_topological_sorter_top;
	import dts_pkg::*;

	localparam int NODES = MAX_NODES_DEF;
	localparam int EDGES = MAX_EDGES_DEF;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_EDGE_CAP = 8;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [NODE_W-1:0]  node_index;
		logic [COUNT_W-1:0] sorted_count;
		logic [MASK_W-1:0]  cyclic_mask;
		logic               last;
	} sort_out_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [COUNT_W-1:0]  cfg_wdata = '0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic [ACT_W-1:0]    action = '0;
	logic [NODE_W-1:0]   edge_from = '0;
	logic [NODE_W-1:0]   edge_to = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic [KIND_W-1:0]   kind;
	logic [NODE_W-1:0]   node_index;
	logic [COUNT_W-1:0]  sorted_count;
	logic [MASK_W-1:0]   cyclic_mask;
	logic                last;

	// sorter state as seen by the testbench
	logic [NODE_W-1:0]   edge_src [EDGES];
	logic [NODE_W-1:0]   edge_dst [EDGES];
	int                  edge_fill = 0;
	int                  node_limit = 0;
	sort_out_t           kahn_outputs [$];

	int                  fail_count = 0;
	int                  items_sent = 0;
	int                  send_idle_pct = 0;
	int                  stall_pct = 0;
	int                  hold_request = 0;
	int                  hold_left = 0;

	dependency_topological_sorter_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.action       (action),
		.edge_from    (edge_from),
		.edge_to      (edge_to),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.kind         (kind),
		.node_index   (node_index),
		.sorted_count (sorted_count),
		.cyclic_mask  (cyclic_mask),
		.last         (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// response stall: random, or held for a counted stretch on request
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		sort_out_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (kahn_outputs.size() == 0) begin
				$error("unexpected result: kind %0d node %0d", kind, node_index);
				fail_count++;
			end else begin
				want = kahn_outputs.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, actual %0d", want.kind, kind);
					fail_count++;
				end
				if (node_index !== want.node_index) begin
					$error("node_index: expected %0d, actual %0d", want.node_index, node_index);
					fail_count++;
				end
				if (sorted_count !== want.sorted_count) begin
					$error("sorted_count: expected %0d, actual %0d",
						want.sorted_count, sorted_count);
					fail_count++;
				end
				if (cyclic_mask !== want.cyclic_mask) begin
					$error("cyclic_mask: expected %h, actual %h", want.cyclic_mask, cyclic_mask);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, last);
					fail_count++;
				end
			end
		end
	end

	task automatic kahn_step(input logic [ACT_W-1:0] act, input logic [NODE_W-1:0] src,
		input logic [NODE_W-1:0] dst);
		int        deg [NODES];
		int        ready [$];
		int        placed;
		int        cur;
		sort_out_t r;
		r = '0;
		r.last = 1'b1;
		case (act)
			ACT_ADD: begin
				if (src >= node_limit || dst >= node_limit) begin
					r.kind = KIND_BAD_NODE;
				end else if (edge_fill >= EDGES) begin
					r.kind = KIND_FULL;
				end else begin
					edge_src[edge_fill] = src;
					edge_dst[edge_fill] = dst;
					edge_fill++;
					r.kind = KIND_STORED;
				end
				kahn_outputs.insert(kahn_outputs.size(), r);
			end
			ACT_CLEAR: begin
				edge_fill = 0;
			end
			ACT_RUN: begin
				for (int i = 0; i < NODES; i++)
					deg[i] = 0;
				for (int e = 0; e < edge_fill; e++)
					if (edge_src[e] < node_limit && edge_dst[e] < node_limit)
						deg[edge_dst[e]]++;
				for (int i = 0; i < node_limit; i++)
					if (deg[i] == 0)
						ready.insert(ready.size(), i);
				placed = 0;
				while (ready.size() != 0) begin
					cur = ready.pop_front();
					placed++;
					r = '0;
					r.kind = KIND_NODE;
					r.node_index = NODE_W'(cur);
					kahn_outputs.insert(kahn_outputs.size(), r);
					for (int e = 0; e < edge_fill; e++) begin
						if (edge_src[e] == cur && edge_dst[e] < node_limit
							&& deg[edge_dst[e]] != 0) begin
							deg[edge_dst[e]]--;
							if (deg[edge_dst[e]] == 0)
								ready.insert(ready.size(), int'(edge_dst[e]));
						end
					end
				end
				r = '0;
				r.kind = KIND_SUMMARY;
				r.sorted_count = COUNT_W'(placed);
				r.last = 1'b1;
				for (int i = 0; i < node_limit; i++)
					if (deg[i] != 0)
						r.cyclic_mask[i] = 1'b1;
				kahn_outputs.insert(kahn_outputs.size(), r);
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input logic [ACT_W-1:0] act, input logic [NODE_W-1:0] src,
		input logic [NODE_W-1:0] dst);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		action    <= act;
		edge_from <= src;
		edge_to   <= dst;
		do @(posedge clk); while (req_stall);
		kahn_step(act, src, dst);
		if (act == ACT_ADD || act == ACT_RUN)
			items_sent++;
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (kahn_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_node_count(input logic [COUNT_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		node_limit = (value > NODES) ? NODES : int'(value);
	endtask

	task automatic send_dag_edge(input int span);
		int src;
		src = $urandom_range(0, span - 2);
		send_item(ACT_ADD, NODE_W'(src), NODE_W'($urandom_range(src + 1, span - 1)));
	endtask

	task automatic test_empty_sort();
		send_item(ACT_RUN, 5'd31, 5'd31);
		send_item(ACT_ADD, 5'd0, 5'd0);
		send_item(ACT_UNUSED, 5'd31, 5'd0);
		send_item(ACT_RUN, 5'd0, 5'd31);
		wait_idle();
	endtask

	task automatic test_node_extremes();
		set_node_count(6'd63);
		send_item(ACT_ADD, 5'd0, 5'd31);
		send_item(ACT_ADD, 5'd31, 5'd31);
		send_item(ACT_ADD, 5'd5, 5'd6);
		send_item(ACT_ADD, 5'd5, 5'd6);
		send_item(ACT_RUN, 5'd0, 5'd0);
		send_item(ACT_CLEAR, 5'd31, 5'd31);
		send_item(ACT_RUN, 5'd0, 5'd0);
		wait_idle();
	endtask

	task automatic test_bad_node();
		set_node_count(6'd5);
		send_item(ACT_ADD, 5'd5, 5'd0);
		send_item(ACT_ADD, 5'd0, 5'd5);
		send_item(ACT_ADD, 5'd31, 5'd31);
		send_item(ACT_ADD, 5'd4, 5'd3);
		send_item(ACT_ADD, 5'd3, 5'd4);
		send_item(ACT_ADD, 5'd1, 5'd4);
		send_item(ACT_RUN, 5'd0, 5'd0);
		wait_idle();
	endtask

	task automatic test_shrunk_count();
		set_node_count(6'd8);
		send_item(ACT_CLEAR, 5'd0, 5'd0);
		send_item(ACT_ADD, 5'd1, 5'd7);
		send_item(ACT_ADD, 5'd7, 5'd0);
		send_item(ACT_ADD, 5'd2, 5'd3);
		send_item(ACT_ADD, 5'd3, 5'd2);
		set_node_count(6'd4);
		send_item(ACT_RUN, 5'd0, 5'd0);
		set_node_count(6'd1);
		send_item(ACT_RUN, 5'd0, 5'd0);
		set_node_count(6'd0);
		send_item(ACT_RUN, 5'd0, 5'd0);
		wait_idle();
	endtask

	task automatic test_store_full();
		set_node_count(6'd33);
		send_item(ACT_CLEAR, 5'd0, 5'd0);
		for (int k = 0; k < EDGES; k++)
			send_dag_edge(NODES);
		send_item(ACT_ADD, 5'd1, 5'd2);
		send_item(ACT_RUN, 5'd0, 5'd0);
		set_node_count(6'd20);
		// bad endpoint wins over a full store
		send_item(ACT_ADD, 5'd25, 5'd1);
		send_item(ACT_ADD, 5'd3, 5'd4);
		send_item(ACT_RUN, 5'd0, 5'd0);
		send_item(ACT_CLEAR, 5'd0, 5'd0);
		send_item(ACT_ADD, 5'd3, 5'd4);
		send_item(ACT_RUN, 5'd0, 5'd0);
		wait_idle();
	endtask

	task automatic test_input_backpressure();
		set_node_count(6'd16);
		send_item(ACT_CLEAR, 5'd0, 5'd0);
		wait_idle();
		@(negedge clk);
		hold_request = 300;
		@(posedge clk);
		for (int k = 0; k < 16; k++)
			send_dag_edge(16);
		send_item(ACT_RUN, 5'd0, 5'd0);
		wait_idle();
	endtask

	task automatic test_random_phase(input int send_pct, input int stall_percent,
		input int item_goal);
		int goal;
		int edge_cnt;
		int pick;
		int src;
		int dst;
		send_idle_pct = send_pct;
		stall_pct     = stall_percent;
		goal = items_sent + item_goal;
		while (items_sent < goal) begin
			if ($urandom_range(0, 9) == 0)
				set_node_count(COUNT_W'($urandom_range(0, 63)));
			else
				set_node_count(COUNT_W'($urandom_range(1, NODES)));
			send_item(ACT_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
			edge_cnt = $urandom_range(0, (3 * node_limit + 2 > RANDOM_EDGE_CAP) ?
				RANDOM_EDGE_CAP : 3 * node_limit + 2);
			for (int k = 0; k < edge_cnt; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 2) begin
					send_item(ACT_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
				end else if (pick < 6) begin
					send_item(ACT_UNUSED, NODE_W'($urandom), NODE_W'($urandom));
				end else if (pick < 12 || node_limit == 0) begin
					send_item(ACT_ADD, NODE_W'($urandom), NODE_W'($urandom));
				end else begin
					src = $urandom_range(0, node_limit - 1);
					dst = $urandom_range(0, node_limit - 1);
					// mostly forward edges so the sort runs deep
					if (src > dst && $urandom_range(0, 9) < 8)
						send_item(ACT_ADD, NODE_W'(dst), NODE_W'(src));
					else
						send_item(ACT_ADD, NODE_W'(src), NODE_W'(dst));
				end
			end
			if ($urandom_range(0, 99) < 15)
				set_node_count(COUNT_W'($urandom_range(0, node_limit)));
			send_item(ACT_RUN, NODE_W'($urandom), NODE_W'($urandom));
			if ($urandom_range(0, 3) == 0)
				send_item(ACT_RUN, NODE_W'($urandom), NODE_W'($urandom));
		end
		wait_idle();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		test_empty_sort();
		test_node_extremes();
		test_bad_node();
		test_shrunk_count();
		test_store_full();
		test_input_backpressure();
		test_random_phase(0, 0, 5);
		test_random_phase(56, 0, 5);
		test_random_phase(0, 56, 5);
		test_random_phase(15, 15, 5);
		wait_idle();
		if (fail_count == 0 && kahn_outputs.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
